/* rtl/dtss_pkg.sv */
package dtss_pkg;
  localparam int MaxSeqDef    = 64;
  localparam int TrackBitsDef = 12;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_ZERO     = 3'd1,
    ERR_HIGH     = 3'd2,
    ERR_DUP      = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_code_t;

  localparam logic CFG_MODE        = 1'b0;
  localparam logic CFG_TRACK_COUNT = 1'b1;
endpackage

/* rtl/disk_track_seek_scheduler.sv */
// channel | handshake          | payload
// in      | start / busy       | in_track, in_last
// out     | out_valid (strobe) | out_served_track .. out_error
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A non-last request runs a duplicate scan over the n stored entries through the
// arrival memory read port. After the last one, SSTF runs an insertion sort (read
// and write-back per compare step), then a delay pass of O(n^2) reads, then emits
// the results one at a time. FIFO mode skips the sort and the delay pass.
// Reset clears control state only; the memories need no clearing.
// Results cannot be stalled; busy holds off start for the whole run.
module disk_track_seek_scheduler
  import dtss_pkg::*;
#(
  parameter int MAX_SEQ    = MaxSeqDef,
  parameter int TRACK_BITS = TrackBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [TRACK_BITS-1:0] in_track,
  input  logic                  in_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [12:0]           cfg_data,
  output logic                  out_valid,
  output logic [TRACK_BITS-1:0] out_served_track,
  output logic                  out_final_res,
  output logic [17:0]           out_total_seek,
  output logic [11:0]           out_delay_sum,
  output logic [5:0]            out_delay_count,
  output logic [5:0]            out_max_delay,
  output logic [TRACK_BITS-1:0] out_max_delay_track,
  output logic [2:0]            out_error
);
  localparam int AW = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
  localparam int CW = $clog2(MAX_SEQ + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SORT_RD, S_SORT_CMP, S_DLY_RDS, S_DLY_RDA, S_DLY_CMP,
    S_OUT_RD, S_OUT_EMIT
  } state_t;

  logic [TRACK_BITS-1:0] arr_mem [MAX_SEQ];
  logic [TRACK_BITS-1:0] srt_mem [MAX_SEQ];
  logic [TRACK_BITS-1:0] arr_q, srt_q;
  logic [AW-1:0] arr_ra, srt_ra, srt_wa;
  logic [TRACK_BITS-1:0] srt_wd;
  logic srt_we;
  logic [TRACK_BITS-1:0] sort_v;

  state_t state_r;
  logic mode_r;
  logic [12:0] tc_r;
  logic [CW-1:0] cnt_r, i_r, j_r;
  logic [TRACK_BITS-1:0] t_r, v_r, head_r, st_r;
  logic last_r;
  logic [17:0] seek_r;
  logic [11:0] dsum_r;
  logic [5:0] dcnt_r, dmax_r;
  logic [TRACK_BITS-1:0] dtrk_r;
  logic [CW-1:0] pos_r;
  logic found_r;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  // memory read/write addresses from the control
  always_comb begin
    // first compare step of an insertion (j == i) takes arrival[i] from the read port
    sort_v = (j_r == i_r) ? arr_q : v_r;
    arr_ra = j_r[AW-1:0];
    srt_ra = i_r[AW-1:0];
    srt_we = 1'b0;
    srt_wa = j_r[AW-1:0];
    srt_wd = sort_v;
    if (state_r == S_SORT_RD) srt_ra = j_r[AW-1:0] - 1'b1;
    if (state_r == S_SORT_CMP) begin
      srt_we = 1'b1;
      if (j_r != '0 && srt_q > sort_v) srt_wd = srt_q;
    end
  end

  always_ff @(posedge clk) begin
    arr_q <= arr_mem[arr_ra];
    srt_q <= srt_mem[srt_ra];
    if (srt_we) srt_mem[srt_wa] <= srt_wd;
    if (start && !busy && cnt_r < CW'(MAX_SEQ)) arr_mem[cnt_r[AW-1:0]] <= in_track;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mode_r <= 1'b0; tc_r <= 13'd4096; cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_MODE) mode_r <= cfg_data[0];
            else tc_r <= cfg_data;
          end
          if (start) begin
            t_r <= in_track; last_r <= in_last; j_r <= '0;
            state_r <= S_SCAN; found_r <= 1'b0;
          end
        end
        S_SCAN: begin
          // arr_q is entry j_r-1 once j_r>0
          logic dup;
          logic [2:0] e;
          dup = found_r || (j_r != '0 && arr_q == t_r);
          found_r <= dup;
          if (j_r < cnt_r) j_r <= j_r + 1'b1;
          else begin
            e = ERR_NONE;
            if (t_r == '0) e = ERR_ZERO;
            else if (32'(t_r) >= 32'(tc_r)) e = ERR_HIGH;
            else if (dup) e = ERR_DUP;
            else if (cnt_r >= CW'(MAX_SEQ)) e = ERR_OVERFLOW;
            if (e != ERR_NONE) begin
              cnt_r <= '0; out_valid <= 1'b1; out_served_track <= '0;
              out_final_res <= 1'b1; out_total_seek <= '0; out_delay_sum <= '0;
              out_delay_count <= '0; out_max_delay <= '0; out_max_delay_track <= '0;
              out_error <= e; state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              if (!last_r) state_r <= S_IDLE;
              else begin
                i_r <= '0; j_r <= '0; head_r <= '0; seek_r <= '0;
                dsum_r <= '0; dcnt_r <= '0; dmax_r <= '0; dtrk_r <= '0;
                state_r <= mode_r ? S_SORT_RD : S_OUT_RD;
              end
            end
          end
        end
        S_SORT_RD: begin
          // with j == i the arrival port reads entry i for the new insertion
          state_r <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          v_r <= sort_v;
          if (j_r != '0 && srt_q > sort_v) begin
            j_r <= j_r - 1'b1; state_r <= S_SORT_RD;
          end else if (i_r + 1'b1 < cnt_r) begin
            i_r <= i_r + 1'b1; j_r <= i_r + 1'b1; state_r <= S_SORT_RD;
          end else begin
            i_r <= '0; j_r <= '0; state_r <= S_DLY_RDS;
          end
        end
        S_DLY_RDS: begin
          found_r <= 1'b0; pos_r <= i_r; state_r <= S_DLY_RDA;
        end
        S_DLY_RDA: begin
          st_r <= srt_q; state_r <= S_DLY_CMP;
        end
        S_DLY_CMP: begin
          logic [CW-1:0] p;
          logic [5:0] d;
          p = pos_r;
          if (!found_r && arr_q == st_r && j_r != '0) p = j_r - 1'b1;
          if (!found_r && arr_q == st_r && j_r != '0) found_r <= 1'b1;
          pos_r <= p;
          if (j_r < cnt_r && !(!found_r && arr_q == st_r && j_r != '0)) begin
            j_r <= j_r + 1'b1;
          end else begin
            d = 6'(i_r - p);
            if (i_r > p) begin
              dsum_r <= dsum_r + 12'(d); dcnt_r <= dcnt_r + 1'b1;
              if (d > dmax_r) begin dmax_r <= d; dtrk_r <= st_r; end
            end
            j_r <= '0;
            if (i_r + 1'b1 < cnt_r) begin i_r <= i_r + 1'b1; state_r <= S_DLY_RDS; end
            else begin i_r <= '0; state_r <= S_OUT_RD; end
          end
        end
        S_OUT_RD: begin
          j_r <= i_r; state_r <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          logic [TRACK_BITS-1:0] t;
          logic [17:0] s;
          logic fin;
          t = mode_r ? srt_q : arr_q;
          s = seek_r + 18'((t > head_r) ? t - head_r : head_r - t);
          fin = (i_r + 1'b1 == cnt_r);
          seek_r <= s; head_r <= t;
          out_valid <= 1'b1; out_served_track <= t; out_final_res <= fin;
          out_total_seek <= fin ? s : '0;
          out_delay_sum <= fin ? dsum_r : '0;
          out_delay_count <= fin ? dcnt_r : '0;
          out_max_delay <= fin ? dmax_r : '0;
          out_max_delay_track <= fin ? dtrk_r : '0;
          out_error <= ERR_NONE;
          if (fin) begin cnt_r <= '0; state_r <= S_IDLE; end
          else begin i_r <= i_r + 1'b1; j_r <= i_r + 1'b1; state_r <= S_OUT_RD; end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid && out_error != ERR_NONE
    |-> out_final_res && out_served_track == '0);
  assert property (@(posedge clk) disable iff (!rst_n) busy |-> !cfg_ready);
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(MAX_SEQ));
endmodule
